// ===== rtl/core/tmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_pkg
// shared types and constants of the two-word message queue
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 5'd16;
  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_MIN   = 5'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } tmf_cmd_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_REFUSED = 1'b1
  } tmf_status_e;

  // control part of the token that walks down the cell row
  typedef struct packed {
    logic valid;
    logic wr;
    logic rd;
    logic refused;
  } tmf_tok_ctl_t;

endpackage : tmf_pkg
`default_nettype wire

// ===== rtl/core/tmf_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmf channel interfaces
// command, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface tmf_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, command, first_word, second_word, input ready);
  modport sink   (input valid, command, first_word, second_word, output ready);
endinterface : tmf_cmd_if

interface tmf_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] read_first;
  logic [31:0] read_second;

  modport source (output valid, status, read_first, read_second, input ready);
  modport sink   (input valid, status, read_first, read_second, output ready);
endinterface : tmf_rsp_if

interface tmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface : tmf_cfg_if
`default_nettype wire

// ===== rtl/core/tmf_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_cell
// one ring slot: stores a message and passes the token to the next cell
// ----------------------------------------------------------------------------
module tmf_cell
  import tmf_pkg::*;
#(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire tmf_tok_ctl_t        ctl_i,
  input  wire logic [IDX_W-1:0]    idx_i,
  input  wire logic [WORD_W-1:0]   wr_first_i,
  input  wire logic [WORD_W-1:0]   wr_second_i,
  input  wire logic [WORD_W-1:0]   rd_first_i,
  input  wire logic [WORD_W-1:0]   rd_second_i,
  output tmf_tok_ctl_t             ctl_o,
  output logic [IDX_W-1:0]         idx_o,
  output logic [WORD_W-1:0]        wr_first_o,
  output logic [WORD_W-1:0]        wr_second_o,
  output logic [WORD_W-1:0]        rd_first_o,
  output logic [WORD_W-1:0]        rd_second_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              hit;
  logic [WORD_W-1:0] first_q;
  logic [WORD_W-1:0] second_q;
  tmf_tok_ctl_t      ctl_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] wr_first_q;
  logic [WORD_W-1:0] wr_second_q;
  logic [WORD_W-1:0] rd_first_q;
  logic [WORD_W-1:0] rd_second_q;

  assign hit = ctl_i.valid && (idx_i == MY_IDX);

  // slot storage, no reset
  always_ff @(posedge clk_i) begin
    if (adv_i && hit && ctl_i.wr) begin
      first_q  <= wr_first_i;
      second_q <= wr_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q       <= idx_i;
      wr_first_q  <= wr_first_i;
      wr_second_q <= wr_second_i;
      rd_first_q  <= (hit && ctl_i.rd) ? first_q  : rd_first_i;
      rd_second_q <= (hit && ctl_i.rd) ? second_q : rd_second_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign idx_o       = idx_q;
  assign wr_first_o  = wr_first_q;
  assign wr_second_o = wr_second_q;
  assign rd_first_o  = rd_first_q;
  assign rd_second_o = rd_second_q;

endmodule : tmf_cell
`default_nettype wire

// ===== rtl/core/tmf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_ctrl
// ring indices, slot count register and full/empty decision
// ----------------------------------------------------------------------------
module tmf_ctrl
  import tmf_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IDX_W = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic                     adv_i,
  input  wire logic                     command_i,
  input  wire logic [WORD_W-1:0]        first_word_i,
  input  wire logic [WORD_W-1:0]        second_word_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [ENTRY_COUNT_W-1:0] cfg_entry_count_i,
  output tmf_tok_ctl_t                  ctl_o,
  output logic [IDX_W-1:0]              idx_o,
  output logic [WORD_W-1:0]             wr_first_o,
  output logic [WORD_W-1:0]             wr_second_o
);

  localparam int unsigned NW   = $clog2(SLOTS + 1);
  localparam int unsigned CW   = NW + ENTRY_COUNT_W;
  localparam int unsigned FW   = IDX_W + 2;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [NW-1:0] SLOTS_N = NW'(SLOTS);
  localparam logic [NW-1:0] MIN_N   = NW'(ENTRY_COUNT_MIN);
  localparam logic signed [FW-1:0] FREE_ONE = FW'(1);

  logic [ENTRY_COUNT_W-1:0] entry_count_q;
  logic [IDX_W-1:0]         widx_q, widx_d;
  logic [IDX_W-1:0]         ridx_q, ridx_d;
  logic [CW-1:0]            ec_wide;
  logic [NW-1:0]            n_slots;
  logic signed [FW-1:0]     wi_s, ri_s, n_s, free_s;
  logic                     is_read, write_ok, read_ok;
  tmf_tok_ctl_t             ctl_q, ctl_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [WORD_W-1:0]        wr_first_q, wr_second_q;

  // next index with wrap at the last slot in use
  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                input logic [NW-1:0]    n);
    logic [NW:0] idx_ext;
    logic [NW:0] n_ext;
    idx_ext = {{(NW + 1 - IDX_W){1'b0}}, idx};
    n_ext   = {1'b0, n};
    if (idx_ext >= n_ext - 1'b1) begin
      step_idx = '0;
    end else begin
      step_idx = idx + 1'b1;
    end
  endfunction

  // clamp the count register to the range from the minimum count to the ring size
  always_comb begin
    ec_wide = {{NW{1'b0}}, entry_count_q};
    if (entry_count_q < ENTRY_COUNT_MIN) begin
      n_slots = MIN_N;
    end else if (ec_wide > SLOTS_C) begin
      n_slots = SLOTS_N;
    end else begin
      n_slots = NW'(ec_wide);
    end
  end

  // signed free count, may go negative after the count shrinks
  always_comb begin
    wi_s = $signed({2'b00, widx_q});
    ri_s = $signed({2'b00, ridx_q});
    n_s  = $signed({{(FW - NW){1'b0}}, n_slots});
    if (widx_q < ridx_q) begin
      free_s = ri_s - wi_s;
    end else begin
      free_s = n_s - wi_s + ri_s;
    end
  end

  assign is_read  = (command_i == CMD_READ);
  assign write_ok = !is_read && (free_s > FREE_ONE);
  assign read_ok  = is_read && (widx_q != ridx_q);

  always_comb begin
    widx_d = widx_q;
    ridx_d = ridx_q;
    ctl_d  = ctl_q;
    idx_d  = idx_q;
    if (accept_i) begin
      ctl_d.valid   = 1'b1;
      ctl_d.wr      = write_ok;
      ctl_d.rd      = read_ok;
      ctl_d.refused = !(write_ok || read_ok);
      idx_d         = is_read ? ridx_q : widx_q;
      if (write_ok) begin
        widx_d = step_idx(widx_q, n_slots);
      end
      if (read_ok) begin
        ridx_d = step_idx(ridx_q, n_slots);
      end
    end else if (adv_i) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RESET;
      widx_q        <= '0;
      ridx_q        <= '0;
      ctl_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_entry_count_i;
      end
      widx_q <= widx_d;
      ridx_q <= ridx_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (accept_i) begin
      wr_first_q  <= first_word_i;
      wr_second_q <= second_word_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign idx_o       = idx_q;
  assign wr_first_o  = wr_first_q;
  assign wr_second_o = wr_second_q;

endmodule : tmf_ctrl
`default_nettype wire

// ===== rtl/core/two_word_message_fifo_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_word_message_fifo_unit
// ring queue of two-word messages built as a row of slot cells
// ----------------------------------------------------------------------------
// Each command item either stores a two-word message (write) or returns the
// oldest one (read), and always yields exactly one response item: status 0
// on success, 1 when a write finds the ring full (one slot is kept empty) or
// a read finds it empty; read words are zero unless a read succeeds. The
// ring has SLOTS cells; cfg sets how many are in use (2..SLOTS, clamped,
// reset 16) and keeps indices and contents. The full/empty decision and the
// index update happen at acceptance; the item then travels as a token down
// the row of SLOTS cells, one cell per cycle unless the row stalls, and the
// cell whose index matches stores or supplies the message. One item is in
// flight at a time: ready drops after acceptance and returns as the response
// enters the output register, so a new item is taken only once the last
// one's token has left the cell row. A waiting response does not block the
// next command; the row only stalls when a finished token meets a still
// occupied output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_word_message_fifo_unit
  import tmf_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tmf_cmd_if.sink    cmd_i,
  tmf_cfg_if.sink    cfg_i,
  tmf_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // token path, stage 0 is the launch register in the control block
  tmf_tok_ctl_t      ctl_s       [SLOTS+1];
  logic [IDX_W-1:0]  idx_s       [SLOTS+1];
  logic [WORD_W-1:0] wr_first_s  [SLOTS+1];
  logic [WORD_W-1:0] wr_second_s [SLOTS+1];
  logic [WORD_W-1:0] rd_first_s  [SLOTS+1];
  logic [WORD_W-1:0] rd_second_s [SLOTS+1];

  logic              accept;
  logic              adv;
  logic              busy_q;
  logic              out_valid_q;
  logic              out_status_q;
  logic [WORD_W-1:0] out_first_q;
  logic [WORD_W-1:0] out_second_q;
  logic              tail_valid;
  logic              tail_take;

  // one item in flight; user gives config writes only when idle, unenforced
  assign cmd_i.ready = !busy_q;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  // row stalls only when a finished token cannot enter the output register
  assign tail_valid = ctl_s[SLOTS].valid;
  assign adv        = !(tail_valid && out_valid_q && !rsp_o.ready);
  assign tail_take  = tail_valid && adv;

  tmf_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .adv_i             (adv),
    .command_i         (cmd_i.command),
    .first_word_i      (cmd_i.first_word),
    .second_word_i     (cmd_i.second_word),
    .cfg_we_i          (cfg_i.valid),
    .cfg_entry_count_i (cfg_i.entry_count),
    .ctl_o             (ctl_s[0]),
    .idx_o             (idx_s[0]),
    .wr_first_o        (wr_first_s[0]),
    .wr_second_o       (wr_second_s[0])
  );

  // read data starts at zero, a matching read cell overwrites it
  assign rd_first_s[0]  = '0;
  assign rd_second_s[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    tmf_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .ctl_i       (ctl_s[k]),
      .idx_i       (idx_s[k]),
      .wr_first_i  (wr_first_s[k]),
      .wr_second_i (wr_second_s[k]),
      .rd_first_i  (rd_first_s[k]),
      .rd_second_i (rd_second_s[k]),
      .ctl_o       (ctl_s[k+1]),
      .idx_o       (idx_s[k+1]),
      .wr_first_o  (wr_first_s[k+1]),
      .wr_second_o (wr_second_s[k+1]),
      .rd_first_o  (rd_first_s[k+1]),
      .rd_second_o (rd_second_s[k+1])
    );
  end

  // busy from acceptance until the token leaves the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail_take) begin
        busy_q <= 1'b0;
      end
      if (tail_take) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response register, the last unused tail words and index are dropped
  always_ff @(posedge clk_i) begin
    if (tail_take) begin
      out_status_q <= ctl_s[SLOTS].refused ? STATUS_REFUSED : STATUS_OK;
      out_first_q  <= rd_first_s[SLOTS];
      out_second_q <= rd_second_s[SLOTS];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_first  = out_first_q;
  assign rsp_o.read_second = out_second_q;

endmodule : two_word_message_fifo_unit
`default_nettype wire
